### rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/fqwe_pkg.sv
package fqwe_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int ELEM_WIDTH_DEF = 32;

    localparam int OP_W       = 3;
    localparam int VAL_W      = 32;
    localparam int ST_W       = 2;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_PAD_W  = OUT_DATA_W - VAL_W - 1;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 3'd0,
        OP_POP   = 3'd1,
        OP_PEEK  = 3'd2,
        OP_ERASE = 3'd3,
        OP_QUERY = 3'd4
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

endpackage

### rtl/fifo_queue_with_erase.sv
// Ordered queue of up to DEPTH words held in one synchronous RAM (one write
// and one read port, read data registered). Each request gives exactly one
// response. Push and query go from acceptance straight to S_RESP; pop and
// peek pass through S_READ for the RAM read first. Erase scans the RAM read
// port one entry per cycle from the front, then the entries behind the
// match are moved forward one per cycle, each move a read and a write-back.
// One request is in flight at a time; a new one is taken as soon as the
// previous response is in the output register.
module fifo_queue_with_erase
    import fqwe_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [VAL_W-1:0]      i_s_axis_tdata,  // [31:0] item_value
    input  logic [OP_W-1:0]       i_s_axis_tuser,  // [2:0] operation
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,  // [31:0] result_value, [32] empty_flag, zero pad
    output logic [ST_W-1:0]       o_m_axis_tuser   // [1:0] status
);

    `include "assert_macros.svh"

    localparam int SW = (ELEM_WIDTH < VAL_W) ? ELEM_WIDTH : VAL_W;
    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_SHIFT,
        S_RESP
    } t_state;

    t_state        r_state;
    t_op           r_op;
    logic [SW-1:0] r_val;
    logic [IW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    t_status       r_status;
    logic [SW-1:0] r_result;

    logic          r_out_valid;
    t_status       r_out_status;
    logic [SW-1:0] r_out_value;
    logic          r_out_empty;

    logic [SW-1:0] r_mem [DEPTH];
    logic [SW-1:0] r_rd_data;

    logic          mem_rd_en;
    logic [IW-1:0] mem_rd_addr;
    logic          mem_wr_en;
    logic [IW-1:0] mem_wr_addr;
    logic [SW-1:0] mem_wr_data;

    logic          s_accept;
    t_op           in_op;
    logic [SW-1:0] in_val;
    logic          q_full;
    logic          q_empty;
    logic          out_free;
    logic [CW-1:0] idx_p1;
    logic [CW-1:0] idx_p2;
    logic          rd_match;

    // slot of the entry at a given offset from the head
    function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] head,
                                              input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW + 1)'(head) + (CW + 1)'(off);
        if (s >= (CW + 1)'(DEPTH)) begin
            s = s - (CW + 1)'(DEPTH);
        end
        return s[IW-1:0];
    endfunction

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign in_op           = t_op'(i_s_axis_tuser);
    assign in_val          = i_s_axis_tdata[SW-1:0];
    assign q_full          = (r_count == CW'(DEPTH));
    assign q_empty         = (r_count == '0);
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign idx_p1          = r_idx + CW'(1);
    assign idx_p2          = r_idx + CW'(2);
    assign rd_match        = (r_rd_data == r_val);

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {OUT_PAD_W'(0), r_out_empty, VAL_W'(r_out_value)};

    always_comb begin
        mem_rd_en   = 1'b0;
        mem_rd_addr = r_head;
        mem_wr_en   = 1'b0;
        mem_wr_addr = slot_of(r_head, r_idx);
        mem_wr_data = r_rd_data;
        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    unique case (in_op)
                        OP_PUSH: begin
                            mem_wr_en   = !q_full;
                            mem_wr_addr = slot_of(r_head, r_count);
                            mem_wr_data = in_val;
                        end
                        OP_POP, OP_PEEK, OP_ERASE: begin
                            mem_rd_en = !q_empty;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = slot_of(r_head, idx_p1);
            end
            S_SHIFT: begin
                // move entry idx+1 down to idx, fetch idx+2 for the next move
                mem_wr_en   = 1'b1;
                mem_rd_en   = 1'b1;
                mem_rd_addr = slot_of(r_head, idx_p2);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_wr_en) begin
            r_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en) begin
            r_rd_data <= r_mem[mem_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a response being loaded this cycle sets valid below instead
            if (r_out_valid && i_m_axis_tready && r_state != S_RESP) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_op     <= in_op;
                        r_val    <= in_val;
                        r_idx    <= '0;
                        r_status <= ST_OK;
                        r_result <= '0;
                        r_state  <= S_RESP;
                        unique case (in_op)
                            OP_PUSH: begin
                                if (q_full) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_count <= r_count + CW'(1);
                                end
                            end
                            OP_POP, OP_PEEK: begin
                                if (q_empty) begin
                                    r_status <= ST_EMPTY;
                                end else begin
                                    r_state <= S_READ;
                                end
                            end
                            OP_ERASE: begin
                                if (q_empty) begin
                                    r_status <= ST_EMPTY;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_result <= r_rd_data;
                    if (r_op == OP_POP) begin
                        r_count <= r_count - CW'(1);
                        if (r_count == CW'(1) || r_head == IW'(DEPTH - 1)) begin
                            r_head <= '0;
                        end else begin
                            r_head <= r_head + IW'(1);
                        end
                    end
                    r_state <= S_RESP;
                end
                S_SCAN: begin
                    if (rd_match) begin
                        if (idx_p1 < r_count) begin
                            r_state <= S_SHIFT;
                        end else begin
                            // match was the last entry: nothing to close up
                            r_count <= r_count - CW'(1);
                            if (r_count == CW'(1)) begin
                                r_head <= '0;
                            end
                            r_state <= S_RESP;
                        end
                    end else if (idx_p1 == r_count) begin
                        r_status <= ST_EMPTY;
                        r_state  <= S_RESP;
                    end else begin
                        r_idx <= idx_p1;
                    end
                end
                S_SHIFT: begin
                    if (idx_p2 < r_count) begin
                        r_idx <= idx_p1;
                    end else begin
                        r_count <= r_count - CW'(1);
                        r_state <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_value  <= r_result;
                        r_out_empty  <= q_empty;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `ASSERT_ALWAYS(a_count_bound, r_count <= CW'(DEPTH), "entry count above depth")
    `ASSERT_IMPL(a_head_when_empty, r_count == '0, r_head == '0, "head not reset on empty queue")
    `ASSERT_IMPL(a_shift_range, r_state == S_SHIFT, idx_p1 < r_count, "shift beyond occupied span")
    `ASSERT_NEXT(a_push_grows, s_accept && in_op == OP_PUSH && !q_full,
                 r_count == $past(r_count) + CW'(1), "push did not grow the queue")
    `ASSERT_IMPL(a_no_overlap, mem_rd_en && mem_wr_en, mem_rd_addr != mem_wr_addr,
                 "read and write of the same entry in one cycle")

endmodule

### tb/sv/fifo_queue_with_erase_checker.sv
module fifo_queue_with_erase_checker
    import fqwe_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    input  logic                  i_req_ready,
    input  logic [VAL_W-1:0]      i_req_value,
    input  logic [OP_W-1:0]       i_req_op,
    input  logic                  i_rsp_valid,
    input  logic                  i_rsp_ready,
    input  logic [OUT_DATA_W-1:0] i_rsp_data,
    input  logic [ST_W-1:0]       i_rsp_status,
    output int                    o_mismatches,
    output int                    o_pending
);

    typedef struct packed {
        t_status          status;
        logic [VAL_W-1:0] value;
        logic             empty;
    } t_queue_reply;

    logic [VAL_W-1:0] stored_words[$];
    t_queue_reply     expected_replies[$];
    int               mismatch_count = 0;
    int               reply_index    = 0;

    // Applies one request to the shadow queue and returns the reply it should give.
    function automatic t_queue_reply apply_request(input logic [OP_W-1:0] op,
                                                   input logic [VAL_W-1:0] value);
        t_queue_reply reply;
        int           hit;
        reply.status = ST_OK;
        reply.value  = '0;
        hit          = -1;
        case (op)
            OP_PUSH: begin
                if (stored_words.size() >= DEPTH_DEF) begin
                    reply.status = ST_FULL;
                end else begin
                    stored_words.push_back(value);
                end
            end
            OP_POP, OP_PEEK: begin
                if (stored_words.size() == 0) begin
                    reply.status = ST_EMPTY;
                end else begin
                    reply.value = stored_words[0];
                    if (op == OP_POP) begin
                        void'(stored_words.pop_front());
                    end
                end
            end
            OP_ERASE: begin
                // only the occurrence nearest the front goes
                foreach (stored_words[i]) begin
                    if (hit < 0 && stored_words[i] == value) begin
                        hit = i;
                    end
                end
                if (hit < 0) begin
                    reply.status = ST_EMPTY;
                end else begin
                    stored_words.delete(hit);
                end
            end
            default: ;  // query and spare codes leave the queue alone
        endcase
        reply.empty = (stored_words.size() == 0);
        return reply;
    endfunction

    function automatic void flag_field(input string field, input logic [VAL_W-1:0] want,
                                       input logic [VAL_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("reply %0d: %s expected %h, got %h", reply_index, field, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_queue_reply want;
        if (!i_rst_n) begin
            stored_words.delete();
            expected_replies.delete();
        end else begin
            if (i_req_valid && i_req_ready) begin
                expected_replies.push_back(apply_request(i_req_op, i_req_value));
            end
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_replies.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("reply %0d arrived with no request outstanding", reply_index);
                    end
                end else begin
                    want = expected_replies.pop_front();
                    if (i_rsp_status !== want.status) begin
                        flag_field("status", VAL_W'(want.status), VAL_W'(i_rsp_status));
                    end
                    if (i_rsp_data[VAL_W-1:0] !== want.value) begin
                        flag_field("result_value", want.value, i_rsp_data[VAL_W-1:0]);
                    end
                    if (i_rsp_data[VAL_W] !== want.empty) begin
                        flag_field("empty_flag", VAL_W'(want.empty), VAL_W'(i_rsp_data[VAL_W]));
                    end
                    if (i_rsp_data[OUT_DATA_W-1:VAL_W+1] !== '0) begin
                        flag_field("pad", '0, VAL_W'(i_rsp_data[OUT_DATA_W-1:VAL_W+1]));
                    end
                end
                reply_index++;
            end
        end
        o_mismatches <= mismatch_count;
        o_pending    <= expected_replies.size();
    end

endmodule

### tb/sv/fifo_queue_with_erase_tb.sv
module fifo_queue_with_erase_tb
    import fqwe_pkg::*;
();

    localparam int STALL_LIMIT     = 5000;
    localparam int HOLD_CYCLES     = 200;
    localparam int TAIL_CYCLES     = 40;
    localparam int ITEMS_PER_PHASE = 230;
    localparam int POOL_SIZE       = 8;
    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

    logic                  clk;
    logic                  rst_n   = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [VAL_W-1:0]      s_data  = '0;  // [31:0] item_value
    logic [OP_W-1:0]       s_user  = OP_QUERY;  // [2:0] operation
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [OUT_DATA_W-1:0] m_data;  // [31:0] result_value, [32] empty_flag, zero pad
    logic [ST_W-1:0]       m_user;  // [1:0] status

    int               send_idle_pct  = 0;
    int               recv_stall_pct = 0;
    int               holds_asked    = 0;
    int               holds_served   = 0;
    int               sent_count     = 0;
    int               mismatches;
    int               pending;
    logic [VAL_W-1:0] value_pool[POOL_SIZE];

    fifo_queue_with_erase i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    fifo_queue_with_erase_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (s_valid),
        .i_req_ready  (s_ready),
        .i_req_value  (s_data),
        .i_req_op     (s_user),
        .i_rsp_valid  (m_valid),
        .i_rsp_ready  (m_ready),
        .i_rsp_data   (m_data),
        .i_rsp_status (m_user),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: random stalls, plus a long hold-off whenever one is asked for.
    initial begin
        forever begin
            @(posedge clk);
            if (holds_served != holds_asked) begin
                holds_served++;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("stalled for %0d cycles with %0d replies outstanding", STALL_LIMIT, pending);
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_request(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] value);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= value;
        s_user  <= op;
        do @(posedge clk); while (!s_ready);
        sent_count++;
    endtask

    // Called only at the step of an acceptance, so valid sees one assignment.
    task automatic drain_replies();
        s_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        if ($urandom_range(0, 3) != 0) begin
            return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        return $urandom();
    endfunction

    // Bias towards pushes or towards pops and erases so the queue swings
    // between full and empty.
    function automatic logic [OP_W-1:0] pick_op(input bit filling);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            return OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        end
        if (roll < (filling ? 56 : 26)) return OP_PUSH;
        if (roll < (filling ? 66 : 58)) return OP_POP;
        if (roll < (filling ? 74 : 66)) return OP_PEEK;
        if (roll < 93) return OP_ERASE;
        return OP_QUERY;
    endfunction

    initial begin : stimulus
        logic [VAL_W-1:0] last_pushed;
        bit               filling;
        last_pushed = '0;
        filling     = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // empty queue corners
        send_request(OP_QUERY, '0);
        send_request(OP_POP, '0);
        send_request(OP_PEEK, '1);
        send_request(OP_ERASE, '0);
        send_request(OP_SPARE_FIRST, '1);
        send_request(OP_SPARE_LAST, '0);
        // duplicates: erase must take the one nearest the front
        send_request(OP_PUSH, '0);
        send_request(OP_PUSH, '1);
        send_request(OP_PUSH, '1);
        send_request(OP_PEEK, '0);
        send_request(OP_ERASE, '1);
        send_request(OP_ERASE, 32'h1234_5678);
        send_request(OP_POP, '0);
        // fill to capacity, refuse one more, then erase the back entry
        repeat (DEPTH_DEF - 1) begin
            last_pushed = $urandom();
            send_request(OP_PUSH, last_pushed);
        end
        send_request(OP_PUSH, 32'hA5A5_A5A5);
        send_request(OP_ERASE, last_pushed);
        send_request(OP_QUERY, '0);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            value_pool[0] = '0;
            value_pool[1] = '1;
            for (int p = 2; p < POOL_SIZE; p++) value_pool[p] = $urandom();
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % 32 == 0) filling = ($urandom_range(0, 1) != 0);
                // long output hold-off while requests keep coming
                if (phase == 0 && n == 60) holds_asked++;
                send_request(pick_op(filling), pick_value());
            end
            drain_replies();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("%0d requests over four pacing phases, free-running to both sides stalling.",
                 sent_count);
        $display("Covered empty and full queue, duplicate and missing erases, spare codes, hold-off.");
        if (mismatches == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d replies missing", mismatches, pending);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
